// ----- rtl/tcc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_pkg
// shared constants and types of the tilt-compensated compass
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int AXIS_W = 26;
  localparam int ACC_W  = 40;
  localparam int Z_W    = 34;
  localparam int NSTAGE_MAX = 24;

  localparam logic signed [AXIS_W-1:0] AXIS_MAX = 26'sh1FFFFFF;
  localparam logic signed [AXIS_W-1:0] AXIS_MIN = -26'sh2000000;
  localparam logic signed [31:0] KSCALE  = 32'sd652032875;
  localparam logic signed [Z_W-1:0] QUARTER = 34'sd1073741824;
  localparam logic signed [Z_W-1:0] HALF    = 34'sd2147483648;

  typedef enum logic [2:0] {
    R_ACCEL_GAIN = 3'd0, R_MAG_GAIN = 3'd1,
    R_ABX = 3'd2, R_ABY = 3'd3, R_ABZ = 3'd4,
    R_MBX = 3'd5, R_MBY = 3'd6, R_MBZ = 3'd7
  } reg_idx_t;

  function automatic logic signed [Z_W-1:0] arc(input int i);
    logic signed [Z_W-1:0] t [NSTAGE_MAX];
    t = '{34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
          34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
          34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
          34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861, 34'sd10430,
          34'sd5215, 34'sd2608, 34'sd1304, 34'sd652, 34'sd326,
          34'sd163, 34'sd81};
    return t[i];
  endfunction

endpackage

// ----- rtl/tcc_atan2.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_atan2
// pipelined vectoring cordic, one stage per register, carries a side payload
// ----------------------------------------------------------------------------
module tcc_atan2 #(
  parameter int STAGES = 16,
  parameter int PW = 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic signed [tcc_pkg::AXIS_W+6:0]    in_y,
  input  logic signed [tcc_pkg::AXIS_W+6:0]    in_x,
  input  logic [PW-1:0]                        in_side,
  output logic                                 out_valid,
  output logic signed [15:0]                   out_ang,
  output logic [PW-1:0]                        out_side
);
  localparam int W  = tcc_pkg::ACC_W;
  localparam int N  = (STAGES < tcc_pkg::NSTAGE_MAX) ? STAGES : tcc_pkg::NSTAGE_MAX;

  logic                          v  [N+1];
  logic signed [W-1:0]           x  [N+1];
  logic signed [W-1:0]           y  [N+1];
  logic signed [tcc_pkg::Z_W-1:0] z [N+1];
  logic                          zr [N+1];
  logic [PW-1:0]                 sd [N+1];

  logic signed [W-1:0] xs, ys;
  logic signed [tcc_pkg::Z_W-1:0] zr_sum;

  // prerotation stage
  always_comb begin
    xs = W'(in_x) <<< 4;
    ys = W'(in_y) <<< 4;
  end

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else v[0] <= in_valid;
    sd[0] <= in_side;
    zr[0] <= (in_x == '0) && (in_y == '0);
    if (xs < 0) begin
      if (ys >= 0) begin
        x[0] <= ys; y[0] <= -xs; z[0] <= tcc_pkg::QUARTER;
      end else begin
        x[0] <= -ys; y[0] <= xs; z[0] <= -tcc_pkg::QUARTER;
      end
    end else begin
      x[0] <= xs; y[0] <= ys; z[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else v[i+1] <= v[i];
      sd[i+1] <= sd[i];
      zr[i+1] <= zr[i];
      if (y[i] >= 0) begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + tcc_pkg::arc(i);
      end else begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - tcc_pkg::arc(i);
      end
    end
  end

  assign zr_sum = z[N] + tcc_pkg::Z_W'(32768);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= v[N];
    out_side <= sd[N];
    out_ang  <= zr[N] ? 16'sd0 : zr_sum[31:16];
  end
endmodule

// ----- rtl/tcc_sincos.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_sincos
// pipelined rotation cordic giving q30 sine and cosine, carries a side payload
// ----------------------------------------------------------------------------
module tcc_sincos #(
  parameter int STAGES = 16,
  parameter int PW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [15:0]   in_ang,
  input  logic [PW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [32:0]   out_sin,
  output logic signed [32:0]   out_cos,
  output logic [PW-1:0]        out_side
);
  localparam int N = (STAGES < tcc_pkg::NSTAGE_MAX) ? STAGES : tcc_pkg::NSTAGE_MAX;
  localparam int ZW = tcc_pkg::Z_W;

  logic                 v  [N+1];
  logic signed [32:0]   x  [N+1];
  logic signed [32:0]   y  [N+1];
  logic signed [ZW-1:0] z  [N+1];
  logic                 ng [N+1];
  logic [PW-1:0]        sd [N+1];
  logic signed [ZW-1:0] za;

  assign za = ZW'(in_ang) <<< 16;

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else v[0] <= in_valid;
    sd[0] <= in_side;
    x[0]  <= 33'(tcc_pkg::KSCALE);
    y[0]  <= '0;
    if (za > tcc_pkg::QUARTER) begin
      z[0] <= za - tcc_pkg::HALF; ng[0] <= 1'b1;
    end else if (za < -tcc_pkg::QUARTER) begin
      z[0] <= za + tcc_pkg::HALF; ng[0] <= 1'b1;
    end else begin
      z[0] <= za; ng[0] <= 1'b0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else v[i+1] <= v[i];
      sd[i+1] <= sd[i];
      ng[i+1] <= ng[i];
      if (z[i] >= 0) begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - tcc_pkg::arc(i);
      end else begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + tcc_pkg::arc(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= v[N];
    out_side <= sd[N];
    out_sin  <= ng[N] ? -y[N] : y[N];
    out_cos  <= ng[N] ? -x[N] : x[N];
  end
endmodule

// ----- rtl/tilt_compensated_compass_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_compensated_compass_top
// tilt-compensated e-compass: axis scaling, roll, pitch and heading by cordic
// ----------------------------------------------------------------------------
// from start to done the data passes three vectoring and two rotation
//   cordic pipelines in series, each with a prerotation and an output
//   register around its stages, and seven product and sum register stages
// throughput: one transfer per cycle, busy is never raised
// reset: synchronous, clears all valid bits and loads register defaults;
//   the receiver cannot stall, each result shows for one cycle with done
// ----------------------------------------------------------------------------
module tilt_compensated_compass_top #(
  parameter int CORDIC_STAGES = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // command side
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] accel_raw_x,
  input  logic signed [15:0] accel_raw_y,
  input  logic signed [15:0] accel_raw_z,
  input  logic signed [15:0] mag_raw_x,
  input  logic signed [15:0] mag_raw_y,
  input  logic signed [15:0] mag_raw_z,
  // result side
  output logic               done,
  output logic signed [15:0] roll_angle,
  output logic signed [15:0] pitch_angle,
  output logic signed [15:0] heading_angle,
  output logic               saturated,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  localparam int AW = tcc_pkg::AXIS_W;
  localparam int OW = AW + 7;   // cordic operand width

  // ---------------- configuration registers ----------------
  logic [17:0]        accel_gain, mag_gain;
  logic signed [24:0] bias [6];
  logic [2:0]         widx;

  assign pready = 1'b1;
  assign widx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_gain <= 18'd16384;
      mag_gain   <= 18'd37581;
      for (int i = 0; i < 6; i++) bias[i] <= '0;
    end else if (psel && penable && pwrite) begin
      case (widx)
        tcc_pkg::R_ACCEL_GAIN: accel_gain <= pwdata[17:0];
        tcc_pkg::R_MAG_GAIN:   mag_gain   <= pwdata[17:0];
        default:               bias[widx - 3'd2] <= pwdata[24:0];
      endcase
    end
  end

  always_comb begin
    case (widx)
      tcc_pkg::R_ACCEL_GAIN: prdata = {14'd0, accel_gain};
      tcc_pkg::R_MAG_GAIN:   prdata = {14'd0, mag_gain};
      default:               prdata = 32'(bias[widx - 3'd2]);
    endcase
  end

  assign busy = 1'b0;

  // ---------------- stage a: sample times gain ----------------
  logic signed [SAMPLE_BITS-1:0] smp [6];
  logic signed [35:0]            prod [6];
  logic                          va;
  assign smp[0] = accel_raw_x[SAMPLE_BITS-1:0];
  assign smp[1] = accel_raw_y[SAMPLE_BITS-1:0];
  assign smp[2] = accel_raw_z[SAMPLE_BITS-1:0];
  assign smp[3] = mag_raw_x[SAMPLE_BITS-1:0];
  assign smp[4] = mag_raw_y[SAMPLE_BITS-1:0];
  assign smp[5] = mag_raw_z[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else va <= start;
    for (int i = 0; i < 6; i++)
      prod[i] <= 36'(smp[i]) * $signed({1'b0, (i < 3) ? accel_gain : mag_gain});
  end

  // ---------------- stage b: bias and clip ----------------
  logic signed [36:0]   diff [6];
  logic signed [AW-1:0] axis [6];
  logic [5:0]           clip;
  logic                 vb, sat_b;
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      diff[i] = 37'(prod[i] >>> 12) - 37'(bias[i]);
      clip[i] = (diff[i] > 37'(tcc_pkg::AXIS_MAX)) || (diff[i] < 37'(tcc_pkg::AXIS_MIN));
    end
  end
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else vb <= va;
    sat_b <= |clip;
    for (int i = 0; i < 6; i++) begin
      if (diff[i] > 37'(tcc_pkg::AXIS_MAX)) axis[i] <= tcc_pkg::AXIS_MAX;
      else if (diff[i] < 37'(tcc_pkg::AXIS_MIN)) axis[i] <= tcc_pkg::AXIS_MIN;
      else axis[i] <= diff[i][AW-1:0];
    end
  end

  // side payload: sat, ax, ay, az, mx, my, mz
  localparam int P1 = 1 + 6 * AW;
  logic [P1-1:0] side_b;
  assign side_b = {sat_b, axis[0], axis[1], axis[2], axis[3], axis[4], axis[5]};

  // ---------------- roll ----------------
  logic               v_r;
  logic signed [15:0] roll;
  logic [P1-1:0]      side_r;
  tcc_atan2 #(.STAGES(CORDIC_STAGES), .PW(P1)) u_roll (
    .clk, .rst, .in_valid(vb), .in_y(OW'(axis[0])), .in_x(OW'(axis[2])),
    .in_side(side_b), .out_valid(v_r), .out_ang(roll), .out_side(side_r));

  localparam int P2 = P1 + 16;
  logic               v_rs;
  logic signed [32:0] sr, cr;
  logic [P2-1:0]      side_rs;
  tcc_sincos #(.STAGES(CORDIC_STAGES), .PW(P2)) u_roll_sc (
    .clk, .rst, .in_valid(v_r), .in_ang(roll), .in_side({roll, side_r}),
    .out_valid(v_rs), .out_sin(sr), .out_cos(cr), .out_side(side_rs));

  // unpack ax and az from {roll, sat, ax, ay, az, mx, my, mz}
  logic signed [AW-1:0] ax_r, az_r;
  assign ax_r = side_rs[5*AW +: AW];
  assign az_r = side_rs[3*AW +: AW];

  // ---------------- pitch denominator: two products, then sum ----------------
  logic signed [59:0] p_axs, p_azc;
  logic signed [32:0] sr_c, cr_c;
  logic [P2-1:0]      side_c;
  logic               vc;
  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else vc <= v_rs;
    p_axs  <= 60'(ax_r) * 60'(sr);
    p_azc  <= 60'(az_r) * 60'(cr);
    sr_c   <= sr;
    cr_c   <= cr;
    side_c <= side_rs;
  end

  logic signed [AW-1:0] ay_c;
  assign ay_c = side_c[4*AW +: AW];

  logic signed [OW-1:0] den_p;
  logic signed [OW-1:0] ny_p;
  logic                 vd;
  localparam int P3 = 16 + 1 + 3 * AW + 66;
  logic [P3-1:0]        side_d;
  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else vd <= vc;
    den_p  <= OW'(p_axs >>> 30) + OW'(p_azc >>> 30);
    ny_p   <= -OW'(ay_c);
    // roll, sat, mx, my, mz, sin and cos of roll
    side_d <= {side_c[P2-1 -: 17], side_c[3*AW-1:0], sr_c, cr_c};
  end

  // ---------------- pitch ----------------
  logic               v_p;
  logic signed [15:0] pitch;
  logic [P3-1:0]      side_p;
  tcc_atan2 #(.STAGES(CORDIC_STAGES), .PW(P3)) u_pitch (
    .clk, .rst, .in_valid(vd), .in_y(ny_p), .in_x(den_p),
    .in_side(side_d), .out_valid(v_p), .out_ang(pitch), .out_side(side_p));

  localparam int P4 = P3 + 16;
  logic               v_ps;
  logic signed [32:0] sp, cp;
  logic [P4-1:0]      side_ps;
  tcc_sincos #(.STAGES(CORDIC_STAGES), .PW(P4)) u_pitch_sc (
    .clk, .rst, .in_valid(v_p), .in_ang(pitch), .in_side({pitch, side_p}),
    .out_valid(v_ps), .out_sin(sp), .out_cos(cp), .out_side(side_ps));

  logic signed [15:0]   pitch_e, roll_e;
  logic                 sat_e;
  logic signed [AW-1:0] mx_e, my_e, mz_e;
  logic signed [32:0]   sr_e, cr_e;
  assign {pitch_e, roll_e, sat_e, mx_e, my_e, mz_e, sr_e, cr_e} = side_ps;

  // ---------------- heading terms, step 1: sp*sr, sp*cr and first products --
  // bx = my, by = mx, bz = -mz
  logic signed [AW:0]   bx_e, by_e, bz_e;
  assign bx_e = (AW+1)'(my_e);
  assign by_e = (AW+1)'(mx_e);
  assign bz_e = -(AW+1)'(mz_e);

  logic signed [65:0] q_spsr, q_spcr;
  logic signed [59:0] q_bzsr, q_bycr, q_bxcp;
  logic signed [AW:0] by_f, bz_f;
  logic [32:0]        hdr_f;
  logic               vf;
  always_ff @(posedge clk) begin
    if (rst) vf <= 1'b0;
    else vf <= v_ps;
    q_spsr <= 66'(sp) * 66'(sr_e);
    q_spcr <= 66'(sp) * 66'(cr_e);
    q_bzsr <= 60'(bz_e) * 60'(sr_e);
    q_bycr <= 60'(by_e) * 60'(cr_e);
    q_bxcp <= 60'(bx_e) * 60'(cp);
    by_f   <= by_e;
    bz_f   <= bz_e;
    hdr_f  <= {pitch_e, roll_e, sat_e};
  end

  // step 2: second-level products and the numerator difference
  logic signed [32:0] spsr_f, spcr_f;
  assign spsr_f = 33'(q_spsr >>> 30);
  assign spcr_f = 33'(q_spcr >>> 30);

  logic signed [59:0] q_by2, q_bz2;
  logic signed [OW-1:0] num_g, t1_g;
  logic [32:0]        hdr_g;
  logic               vg;
  always_ff @(posedge clk) begin
    if (rst) vg <= 1'b0;
    else vg <= vf;
    q_by2 <= 60'(by_f) * 60'(spsr_f);
    q_bz2 <= 60'(bz_f) * 60'(spcr_f);
    num_g <= OW'(q_bzsr >>> 30) - OW'(q_bycr >>> 30);
    t1_g  <= OW'(q_bxcp >>> 30);
    hdr_g <= hdr_f;
  end

  // step 3: sum
  logic signed [OW-1:0] num_h, den_h;
  logic [32:0]          hdr_h;
  logic                 vh;
  always_ff @(posedge clk) begin
    if (rst) vh <= 1'b0;
    else vh <= vg;
    num_h <= num_g;
    den_h <= t1_g + OW'(q_by2 >>> 30) + OW'(q_bz2 >>> 30);
    hdr_h <= hdr_g;
  end

  // ---------------- heading ----------------
  logic               v_y;
  logic signed [15:0] yaw;
  logic [32:0]        hdr_y;
  tcc_atan2 #(.STAGES(CORDIC_STAGES), .PW(33)) u_yaw (
    .clk, .rst, .in_valid(vh), .in_y(num_h), .in_x(den_h),
    .in_side(hdr_h), .out_valid(v_y), .out_ang(yaw), .out_side(hdr_y));

  assign done          = v_y;
  assign heading_angle = yaw;
  assign {pitch_angle, roll_angle, saturated} = hdr_y;

  // ---------------- assertions ----------------
  a_busy_low: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_vb: assert property (@(posedge clk) disable iff (rst) vb |-> $past(start, 2))
    else $error("scale stage valid without a start");
  a_pitch: assert property (@(posedge clk) disable iff (rst) vd |-> $past(v_rs, 2))
    else $error("pitch operands valid without roll trig");
  a_sat_out: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> !$isunknown(heading_angle))
    else $error("bad result on saturated item");
endmodule

// ----- test/tilt_compensated_compass_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_compensated_compass_checker
// predicts roll, pitch and heading for every accepted sample and compares
// them with the results marked by done, in order
// ----------------------------------------------------------------------------
module tilt_compensated_compass_checker #(
  parameter int CORDIC_STAGES = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] accel_raw_x,
  input  logic signed [15:0] accel_raw_y,
  input  logic signed [15:0] accel_raw_z,
  input  logic signed [15:0] mag_raw_x,
  input  logic signed [15:0] mag_raw_y,
  input  logic signed [15:0] mag_raw_z,
  input  logic               done,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] heading_angle,
  input  logic               saturated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);
  typedef struct packed {
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] heading;
    logic        sat;
  } attitude_t;

  localparam longint AX_HI = 64'sd33554431;
  localparam longint AX_LO = -64'sd33554432;
  localparam longint QTR = 64'sd1073741824;
  localparam longint HLF = 64'sd2147483648;
  localparam longint KROT = 64'sd652032875;

  longint arc_turn [24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  logic [31:0] shadow_regs [8];
  attitude_t   attitude_q [$];

  // arithmetic shift of longint rounds toward minus infinity
  function automatic longint sext_raw(logic [15:0] r);
    longint v;
    v = longint'(r) & ((64'sd1 <<< SAMPLE_BITS) - 1);
    if (v[SAMPLE_BITS-1]) v = v - (64'sd1 <<< SAMPLE_BITS);
    return v;
  endfunction

  function automatic longint axis_value(logic [15:0] r, logic [31:0] gain,
                                        logic [31:0] bias, inout logic sat);
    longint v;
    v = ((sext_raw(r) * longint'(gain[17:0])) >>> 12) - longint'($signed(bias[24:0]));
    if (v > AX_HI) begin
      sat = 1'b1;
      v = AX_HI;
    end else if (v < AX_LO) begin
      sat = 1'b1;
      v = AX_LO;
    end
    return v;
  endfunction

  function automatic logic [15:0] vector_angle(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 16'd0;
    x = x * 16;
    y = y * 16;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = QTR;
      end else begin
        x = -y; y = t; z = -QTR;
      end
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arc_turn[i];
      end else begin
        x -= dx; y += dy; z -= arc_turn[i];
      end
    end
    t = (z + 32768) >>> 16;
    return t[15:0];
  endfunction

  function automatic void rotate_angle(logic [15:0] ang, output longint s,
                                       output longint c);
    longint z, x, y, dx, dy;
    logic flip;
    z = longint'($signed(ang)) * 65536;
    x = KROT;
    y = 0;
    flip = 1'b0;
    if (z > QTR) begin
      z -= HLF; flip = 1'b1;
    end else if (z < -QTR) begin
      z += HLF; flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arc_turn[i];
      end else begin
        x += dx; y -= dy; z += arc_turn[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint q30(longint a, longint q);
    return (a * q) >>> 30;
  endfunction

  function automatic attitude_t compass_solution(logic [15:0] a_x, logic [15:0] a_y,
      logic [15:0] a_z, logic [15:0] m_x, logic [15:0] m_y, logic [15:0] m_z);
    attitude_t r;
    logic sat;
    longint ax, ay, az, mx, my, mz, sr, cr, sp, cp, num, den;
    sat = 1'b0;
    ax = axis_value(a_x, shadow_regs[tcc_pkg::R_ACCEL_GAIN], shadow_regs[tcc_pkg::R_ABX],
                    sat);
    ay = axis_value(a_y, shadow_regs[tcc_pkg::R_ACCEL_GAIN], shadow_regs[tcc_pkg::R_ABY],
                    sat);
    az = axis_value(a_z, shadow_regs[tcc_pkg::R_ACCEL_GAIN], shadow_regs[tcc_pkg::R_ABZ],
                    sat);
    mx = axis_value(m_x, shadow_regs[tcc_pkg::R_MAG_GAIN], shadow_regs[tcc_pkg::R_MBX],
                    sat);
    my = axis_value(m_y, shadow_regs[tcc_pkg::R_MAG_GAIN], shadow_regs[tcc_pkg::R_MBY],
                    sat);
    mz = axis_value(m_z, shadow_regs[tcc_pkg::R_MAG_GAIN], shadow_regs[tcc_pkg::R_MBZ],
                    sat);
    r.roll = vector_angle(ax, az);
    rotate_angle(r.roll, sr, cr);
    den = q30(ax, sr) + q30(az, cr);
    r.pitch = vector_angle(-ay, den);
    rotate_angle(r.pitch, sp, cp);
    // body frame remap: bx = mag y, by = mag x, bz = -mag z
    num = q30(-mz, sr) - q30(mx, cr);
    den = q30(my, cp) + q30(mx, q30(sp, sr)) + q30(-mz, q30(sp, cr));
    r.heading = vector_angle(num, den);
    r.sat = sat;
    return r;
  endfunction

  assign pending = attitude_q.size();

  always @(posedge clk) begin
    attitude_t want;
    if (rst) begin
      shadow_regs = '{32'd16384, 32'd37581, 0, 0, 0, 0, 0, 0};
      attitude_q.delete();
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[4:2] <= tcc_pkg::R_MBZ)
        shadow_regs[paddr[4:2]] = (paddr[4:2] < tcc_pkg::R_ABX) ? (pwdata & 32'h3FFFF)
                                                                : (pwdata & 32'h1FFFFFF);
      if (start && !busy)
        attitude_q.push_back(compass_solution(accel_raw_x, accel_raw_y, accel_raw_z,
                                              mag_raw_x, mag_raw_y, mag_raw_z));
      if (done) begin
        if (attitude_q.size() == 0) begin
          $error("result with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = attitude_q.pop_front();
          if (want.roll !== roll_angle || want.pitch !== pitch_angle ||
              want.heading !== heading_angle || want.sat !== saturated)
            fail_count <= fail_count + 1;
          if (want.roll !== roll_angle)
            $error("roll_angle expected %0d got %0d", $signed(want.roll), roll_angle);
          if (want.pitch !== pitch_angle)
            $error("pitch_angle expected %0d got %0d", $signed(want.pitch), pitch_angle);
          if (want.heading !== heading_angle)
            $error("heading_angle expected %0d got %0d", $signed(want.heading),
                   heading_angle);
          if (want.sat !== saturated)
            $error("saturated expected %0b got %0b", want.sat, saturated);
        end
      end
    end
  end
endmodule

// ----- test/tilt_compensated_compass_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_compensated_compass_top_tb
// drives sensor samples and register settings into the compass; a checker
// beside the block predicts each attitude result and counts mismatches
// ----------------------------------------------------------------------------
module tilt_compensated_compass_top_tb;
  localparam int LATENCY = 5 * 16 + 17;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, saturated, pready;
  logic signed [15:0] accel_raw_x = '0, accel_raw_y = '0, accel_raw_z = '0;
  logic signed [15:0] mag_raw_x = '0, mag_raw_y = '0, mag_raw_z = '0;
  logic signed [15:0] roll_angle, pitch_angle, heading_angle;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  int fail_count, pending;
  int cycle_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tilt_compensated_compass_top dut (.*);
  tilt_compensated_compass_checker chk (.*);

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tilt_compensated_compass_top_tb NOT OK");
      $finish;
    end
  end

  // apb write: setup cycle then access cycle
  task automatic write_reg(tcc_pkg::reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // one sample transfer; when may_idle is set, sometimes an idle burst before it
  task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             logic [15:0] mx, logic [15:0] my, logic [15:0] mz,
                             bit may_idle);
    int gap;
    gap = (may_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    accel_raw_x <= ax; accel_raw_y <= ay; accel_raw_z <= az;
    mag_raw_x <= mx; mag_raw_y <= my; mag_raw_z <= mz;
    do @(posedge clk); while (busy);
  endtask

  task automatic end_burst();
    start <= 1'b0;
  endtask

  // wait for every expected transfer to come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // random sample, mostly realistic magnitudes, some full range
  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 8000)) - 4000);
      2: return 16'($signed($urandom_range(0, 600)) - 300);
      default: return 16'($signed($urandom_range(0, 40000)) - 20000);
    endcase
  endfunction

  function automatic logic [31:0] rand_bias();
    case ($urandom_range(0, 2))
      0: return 32'($urandom) & 32'h1FFFFFF;
      1: return 32'($signed($urandom_range(0, 20000)) - 10000) & 32'h1FFFFFF;
      default: return 32'h0;
    endcase
  endfunction

  initial begin
    logic [15:0] ext [6];
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: reset registers, extremes, zero vector, rounding near pi
    ext = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h5555};
    send_sample(0, 0, 0, 0, 0, 0, 0);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
    send_sample(0, 0, 16'h8000, 16'h7FFF, 0, 0, 0);       // az negative, ax 0
    send_sample(16'hFFFF, 0, 16'h8000, 0, 16'h8000, 0, 0); // near minus pi
    send_sample(16'h0001, 16'hFFFF, 16'h4000, 16'hAAAA, 16'h5555, 16'hAAAA, 0);
    for (int i = 0; i < 6; i++)
      send_sample(ext[i], ext[(i + 1) % 6], ext[(i + 2) % 6], ext[(i + 3) % 6],
                  ext[(i + 4) % 6], ext[(i + 5) % 6], 0);
    drain();

    // max gains and extreme biases drive clipping
    write_reg(tcc_pkg::R_ACCEL_GAIN, 32'h3FFFF);
    write_reg(tcc_pkg::R_MAG_GAIN, 32'h3FFFF);
    write_reg(tcc_pkg::R_ABX, 32'h0FFFFFF);
    write_reg(tcc_pkg::R_ABY, 32'h1000000);
    write_reg(tcc_pkg::R_ABZ, 32'h0000001);
    write_reg(tcc_pkg::R_MBX, 32'h1000000);
    write_reg(tcc_pkg::R_MBY, 32'h0FFFFFF);
    write_reg(tcc_pkg::R_MBZ, 32'h1FFFFFF);
    for (int i = 0; i < 6; i++)
      send_sample(ext[i], ext[5 - i], ext[(i + 3) % 6], ext[i], ext[(i + 2) % 6],
                  ext[(i + 4) % 6], 0);
    drain();
    // zero gains: every axis is minus its bias
    write_reg(tcc_pkg::R_ACCEL_GAIN, 32'h0);
    write_reg(tcc_pkg::R_MAG_GAIN, 32'h0);
    send_sample(16'h7FFF, 16'h8000, 16'h1234, 16'h7FFF, 16'h8000, 16'h1234, 0);
    drain();

    // random phases with fresh settings in between
    for (int ph = 0; ph < 8; ph++) begin
      repeat (LATENCY) @(posedge clk);
      write_reg(tcc_pkg::R_ACCEL_GAIN,
                ph == 0 ? 32'd16384 : 32'($urandom_range(0, 32'h3FFFF)));
      write_reg(tcc_pkg::R_MAG_GAIN,
                ph == 0 ? 32'd37581 : 32'($urandom_range(0, 32'h3FFFF)));
      for (int r = tcc_pkg::R_ABX; r <= tcc_pkg::R_MBZ; r++)
        write_reg(tcc_pkg::reg_idx_t'(r), ph == 0 ? 32'h0 : rand_bias());
      for (int n = 0; n < 100; n++) begin
        send_sample(rand_axis(), rand_axis(), rand_axis(), rand_axis(), rand_axis(),
                    rand_axis(), ph < 7);
        if (ph == 3 && n == 50) drain();
      end
      drain();
    end

    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0)
      $display("tilt_compensated_compass_top_tb OK");
    else
      $display("tilt_compensated_compass_top_tb NOT OK");
    $finish;
  end
endmodule
